@@ src/rla_pkg.sv @@
// Shared types and constants for the route length accumulator.
`default_nettype none
package rla_pkg;

  localparam int LatW = 28;
  localparam int LonW = 29;
  localparam int SegW = 32;
  localparam int TotW = 40;
  localparam int CosFracDefault = 16;
  localparam int CordicSteps = 32;
  localparam int AngW = 32;
  localparam logic [SegW-1:0] SegMax = '1;
  localparam logic [TotW-1:0] TotMax = '1;
  localparam logic signed [35:0] CordicGain = 36'sd2608131497;
  localparam logic signed [AngW-1:0] QuarterTurn = 32'sd180000000;
  localparam logic signed [AngW-1:0] HalfTurn = 32'sd360000000;

  // One classified segment job handed from front to back.
  typedef struct packed {
    logic              have_prev;
    logic              last;
    logic [LatW-1:0]   dlat;
    logic [LonW:0]     dlon;
    logic [AngW-1:0]   angle;
  } rla_job_t;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    begin
      unique case (idx)
        5'd0: v = 32'sd90000000;
        5'd1: v = 32'sd53130102;
        5'd2: v = 32'sd28072487;
        5'd3: v = 32'sd14250033;
        5'd4: v = 32'sd7152669;
        5'd5: v = 32'sd3579821;
        5'd6: v = 32'sd1790347;
        5'd7: v = 32'sd895228;
        5'd8: v = 32'sd447621;
        5'd9: v = 32'sd223811;
        5'd10: v = 32'sd111906;
        5'd11: v = 32'sd55953;
        5'd12: v = 32'sd27976;
        5'd13: v = 32'sd13988;
        5'd14: v = 32'sd6994;
        5'd15: v = 32'sd3497;
        5'd16: v = 32'sd1749;
        5'd17: v = 32'sd874;
        5'd18: v = 32'sd437;
        5'd19: v = 32'sd219;
        5'd20: v = 32'sd109;
        5'd21: v = 32'sd55;
        5'd22: v = 32'sd27;
        5'd23: v = 32'sd14;
        5'd24: v = 32'sd7;
        5'd25: v = 32'sd3;
        5'd26: v = 32'sd2;
        5'd27: v = 32'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

@@ src/rla_front.sv @@
// Front end: accepts points, forms deltas and mean-latitude angle, keeps previous point.
`default_nettype none
module rla_front import rla_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [LatW-1:0] latitude,
  input  wire logic signed [LonW-1:0] longitude,
  input  wire logic                   last_point,
  output logic                        job_valid,
  input  wire logic                   job_ready,
  output rla_job_t                    job
);

  logic signed [LatW-1:0] prev_latitude;
  logic signed [LonW-1:0] prev_longitude;
  logic                   have_previous;
  logic signed [LatW:0]   dlat_s;
  logic signed [LonW:0]   dlon_s;
  logic signed [LatW:0]   asum;
  logic [LatW:0]          aabs;
  logic signed [AngW-1:0] afold;

  // One-entry queue slot between front and back.
  assign in_ready = !job_valid || job_ready;

  always_comb begin
    dlat_s = {latitude[LatW-1], latitude} - {prev_latitude[LatW-1], prev_latitude};
    dlon_s = {longitude[LonW-1], longitude} - {prev_longitude[LonW-1], prev_longitude};
    asum = {latitude[LatW-1], latitude} + {prev_latitude[LatW-1], prev_latitude};
    // Magnitude kept unsigned so the most negative sum still folds correctly.
    aabs = asum[LatW] ? -asum : asum;
    afold = AngW'(aabs);
    if (afold > QuarterTurn) begin
      afold = HalfTurn - afold;
    end
    if (afold < 0) begin
      afold = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      have_previous <= 1'b0;
      prev_latitude <= '0;
      prev_longitude <= '0;
    end else begin
      if (job_ready) begin
        job_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        job_valid <= 1'b1;
        job.have_prev <= have_previous;
        job.last <= last_point;
        job.dlat <= LatW'(dlat_s[LatW] ? -dlat_s : dlat_s);
        job.dlon <= (LonW+1)'(dlon_s[LonW] ? -dlon_s : dlon_s);
        job.angle <= afold;
        if (last_point) begin
          have_previous <= 1'b0;
          prev_latitude <= '0;
          prev_longitude <= '0;
        end else begin
          have_previous <= 1'b1;
          prev_latitude <= latitude;
          prev_longitude <= longitude;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/rla_back.sv @@
// Back end: CORDIC cosine, leg scaling, rounded square root, saturating total.
`default_nettype none
module rla_back import rla_pkg::*; #(
  parameter int COS_FRACTION_BITS = CosFracDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_valid,
  output logic            job_ready,
  input  rla_job_t        job,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [SegW-1:0] segment_length,
  output logic [TotW-1:0] total_length,
  output logic            route_done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CORDIC = 4'd1;
  localparam logic [3:0] S_LEGS = 4'd2;
  localparam logic [3:0] S_SQ = 4'd3;
  localparam logic [3:0] S_BDIV = 4'd4;
  localparam logic [3:0] S_BFIN = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;
  localparam int CosW = COS_FRACTION_BITS + 1;
  // 2^19 = 25 * 20971 + 13; the reciprocal is exact for the small remainder part.
  localparam logic [14:0] Div25Hi = 15'd20971;
  localparam logic [22:0] Div25Lo = 23'd13;
  localparam logic [23:0] Div25Recip = 24'd10737419;

  logic [3:0]             state;
  logic [4:0]             step;
  logic signed [35:0]     cx;
  logic signed [35:0]     cy;
  logic signed [AngW-1:0] cz;
  logic                   last;
  logic                   have_prev;
  logic [LatW-1:0]        dlat;
  logic [LonW:0]          dlon;
  logic [CosW-1:0]        cosv;
  logic [33:0]            leg_a;
  logic [33:0]            leg_b;
  logic [33:0]            a_hi;
  logic [22:0]            a_lo;
  logic [33:0]            b_hi;
  logic [22:0]            b_lo;
  logic [LonW+8:0]        uv;
  logic [65:0]            rem;
  logic [65:0]            res;
  logic [65:0]            bitv;
  logic                   sat;
  logic [TotW-1:0]        total;

  logic signed [35:0]     xs;
  logic signed [35:0]     ys;
  logic signed [35:0]     xc;
  logic [35:0]            cr;
  logic [CosW-1:0]        cos_calc;
  logic [LonW+CosW:0]     prod;
  logic [LonW+8:0]        uval;
  logic [40:0]            a_num;
  logic [LonW+20:0]       b_num;
  logic [66:0]            trial;
  logic [TotW:0]          tsum;
  logic [SegW-1:0]        seg_final;

  // Divide by 25: split off the upper bits, then a reciprocal.
  function automatic logic [33:0] div25_hi(input logic [37:0] x);
    return 34'(x[37:19]) * 34'(Div25Hi);
  endfunction

  function automatic logic [22:0] div25_lo(input logic [37:0] x);
    return 23'(x[37:19]) * Div25Lo + 23'(x[18:0]);
  endfunction

  function automatic logic [33:0] div25_fin(input logic [33:0] hi, input logic [22:0] lo);
    logic [46:0] p;
    p = 47'(lo) * 47'(Div25Recip);
    return hi + 34'(p[46:28]);
  endfunction

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    xs = cx >>> step;
    ys = cy >>> step;
    xc = cx;
    if (xc < 0) begin
      xc = '0;
    end
    if (xc > 36'sd4294967296) begin
      xc = 36'sd4294967296;
    end
    cr = (36'(xc) + (36'd1 << (31 - COS_FRACTION_BITS))) >> (32 - COS_FRACTION_BITS);
    cos_calc = (cr > (36'd1 << COS_FRACTION_BITS)) ? (CosW'(1) << COS_FRACTION_BITS)
                                                  : CosW'(cr);
    prod = (LonW+CosW+1)'(dlon) * (LonW+CosW+1)'(cosv);
    uval = (LonW+9)'((prod + ((LonW+CosW+1)'(1) << (COS_FRACTION_BITS - 9)))
                     >> (COS_FRACTION_BITS - 8));
    a_num = 41'd1113 * 41'(dlat) + 41'd50;
    b_num = (LonW+21)'(1113) * (LonW+21)'(uv) + (LonW+21)'(12800);
    trial = 67'(res) + 67'(bitv);
    seg_final = (sat || (res + ((rem > res) ? 66'd1 : 66'd0)) > 66'(SegMax)) ? SegMax
              : SegW'(res + ((rem > res) ? 66'd1 : 66'd0));
    tsum = {1'b0, total} + (TotW+1)'(seg_final);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            last <= job.last;
            have_prev <= job.have_prev;
            dlat <= job.dlat;
            dlon <= job.dlon;
            cx <= CordicGain;
            cy <= '0;
            cz <= job.angle;
            step <= '0;
            state <= job.have_prev ? S_CORDIC : S_DONE;
            segment_length <= '0;
          end
        end
        S_CORDIC: begin
          // One rotation per cycle.
          if (cz >= 0) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_entry(step);
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_entry(step);
          end
          step <= step + 5'd1;
          if (step == 5'(CordicSteps - 1)) begin
            state <= S_LEGS;
          end
        end
        S_LEGS: begin
          // Latitude leg: divide by 100 as a shift by two, then by 25.
          cosv <= cos_calc;
          a_hi <= div25_hi(a_num[39:2]);
          a_lo <= div25_lo(a_num[39:2]);
          state <= S_SQ;
        end
        S_SQ: begin
          leg_a <= div25_fin(a_hi, a_lo);
          uv <= uval;
          state <= S_BDIV;
        end
        S_BDIV: begin
          // Longitude leg: divide by 25600 as a shift by ten, then by 25.
          b_hi <= div25_hi(b_num[47:10]);
          b_lo <= div25_lo(b_num[47:10]);
          state <= S_BFIN;
        end
        S_BFIN: begin
          leg_b <= div25_fin(b_hi, b_lo);
          state <= S_SQRT;
          sat <= 1'b0;
          res <= '0;
          bitv <= 66'd1 << 64;
        end
        S_SQRT: begin
          if (bitv == (66'd1 << 64)) begin
            // First pass: form the sum of squares.
            if (leg_a > 34'(SegMax) || leg_b > 34'(SegMax)) begin
              sat <= 1'b1;
            end
            rem <= 66'(leg_a[31:0]) * 66'(leg_a[31:0]) + 66'(leg_b[31:0]) * 66'(leg_b[31:0]);
            bitv <= 66'd1 << 62;
          end else begin
            if (rem[65:64] != 2'b00) begin
              sat <= 1'b1;
            end
            if (67'(rem) >= trial) begin
              rem <= rem - 66'(trial);
              res <= (res >> 1) + bitv;
            end else begin
              res <= res >> 1;
            end
            bitv <= bitv >> 2;
            if (bitv == 66'd1) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (have_prev) begin
            segment_length <= seg_final;
            total_length <= tsum[TotW] ? TotMax : tsum[TotW-1:0];
            total <= last ? '0 : (tsum[TotW] ? TotMax : tsum[TotW-1:0]);
          end else begin
            total_length <= total;
            if (last) begin
              total <= '0;
            end
          end
          route_done <= last;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/route_length_accumulator.sv @@
// Top level of the route length accumulator.
//
// Points enter on the s_axis channel: tdata holds latitude (bits 27:0) and
// longitude (bits 56:28), both signed microdegrees; tlast marks the last point
// of a route. Each point gives one item on m_axis: segment length (31:0, cm)
// and saturating running total (71:32, cm); tlast closes the route.
// The front registers the point deltas and the folded mean-latitude angle in
// a one-entry queue, so the next point is taken while the back end works.
// The back end runs a 32-step CORDIC (one step per cycle), leg scaling and
// division in the S_LEGS, S_SQ, S_BDIV and S_BFIN states, and a restoring
// square root. It takes no new point until its result has left on m_axis.
// A result waits in the output register while m_axis_tready is low; the front
// still takes one further point meanwhile. Reset clears the previous point,
// the running total and all valid flags.
`default_nettype none
module route_length_accumulator import rla_pkg::*; #(
  parameter int COS_FRACTION_BITS = CosFracDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // latitude[27:0], longitude[56:28], zero fill
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // segment_length[31:0], total_length[71:32]
  output logic             m_axis_tlast
);

  logic            job_valid;
  logic            job_ready;
  rla_job_t        job;
  logic [SegW-1:0] segment_length;
  logic [TotW-1:0] total_length;

  rla_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .latitude(s_axis_tdata[LatW-1:0]),
    .longitude(s_axis_tdata[LatW+LonW-1:LatW]),
    .last_point(s_axis_tlast),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  rla_back #(.COS_FRACTION_BITS(COS_FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .segment_length(segment_length), .total_length(total_length),
    .route_done(m_axis_tlast)
  );

  assign m_axis_tdata = {total_length, segment_length};

endmodule
`default_nettype wire

@@ src/rla_checker.sv @@
// Port-level checker for the route length accumulator, bound to the top level.
`default_nettype none
module rla_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("back end produced items without a pass between them");

  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
    else $error("output tlast changed while stalled");

endmodule

bind route_length_accumulator rla_checker u_rla_checker (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
